// ----- sv/sg_pkg.sv -----
// Shared types and constants of the streaming 3x3 Sobel gradient block.
package sg_pkg;

	localparam int DATA_W = 8;
	localparam int GRAD_W = 11;
	localparam int COORD_W = 10;
	localparam int CHAN_IDX_W = 2;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CHAN_CFG_W = 3;

	localparam int MIN_DIM = 3;
	localparam int RESET_WIDTH = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int GRAD_LIMIT = 1020;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT  = 2'd1,
		REG_CHANNEL_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic interior;
		logic frame_last;
	} sg_flags_t;

	typedef struct packed {
		logic [DATA_W-1:0] top_old;
		logic [DATA_W-1:0] mid_old;
		logic [DATA_W-1:0] bot_old;
		logic [DATA_W-1:0] top_new;
		logic [DATA_W-1:0] mid_new;
		logic [DATA_W-1:0] bot_new;
	} sg_hist_t;

endpackage

// ----- sv/sg_in_if.sv -----
// Input channel: one sample item with its frame start mark.
interface sg_in_if;
	logic                        valid;
	logic                        ready;
	logic [sg_pkg::DATA_W-1:0]   sample;
	logic                        frame_begin;

	modport source (output valid, output sample, output frame_begin, input ready);
	modport sink (input valid, input sample, input frame_begin, output ready);
endinterface

// ----- sv/sg_out_if.sv -----
// Output channel: one gradient result item with its position.
interface sg_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [sg_pkg::GRAD_W-1:0]  grad_x;
	logic signed [sg_pkg::GRAD_W-1:0]  grad_y;
	logic [sg_pkg::COORD_W-1:0]        center_col;
	logic [sg_pkg::COORD_W-1:0]        center_row;
	logic [sg_pkg::CHAN_IDX_W-1:0]     channel_index;
	logic                              frame_last;

	modport source (output valid, output grad_x, output grad_y, output center_col,
		output center_row, output channel_index, output frame_last, input ready);
	modport sink (input valid, input grad_x, input grad_y, input center_col,
		input center_row, input channel_index, input frame_last, output ready);
endinterface

// ----- sv/sg_position.sv -----
// Frame geometry registers and the column, row and channel counters.
module sg_position #(
	parameter int WIDTH_LIMIT = 1024,
	parameter int HEIGHT_LIMIT = 1024,
	parameter int MAX_CHANNELS = 4,
	parameter int COL_W = 10,
	parameter int ROW_W = 10,
	parameter int CH_W = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sg_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                              accept,
	input  logic                              frame_begin,
	output logic [COL_W-1:0]                  cur_col,
	output logic [ROW_W-1:0]                  cur_row,
	output logic [CH_W-1:0]                   cur_ch,
	output sg_pkg::sg_flags_t                 flags
);

	localparam int DIM_W = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int CMP_W = ((DIM_W > sg_pkg::CFG_DATA_W) ? DIM_W : sg_pkg::CFG_DATA_W) + 1;
	localparam int RST_COL = ((WIDTH_LIMIT < sg_pkg::RESET_WIDTH) ? WIDTH_LIMIT
		: sg_pkg::RESET_WIDTH) - 1;
	localparam int RST_ROW = ((HEIGHT_LIMIT < sg_pkg::RESET_HEIGHT) ? HEIGHT_LIMIT
		: sg_pkg::RESET_HEIGHT) - 1;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CH_W-1:0]  ch_q;
	logic [COL_W-1:0] last_col_q;
	logic [ROW_W-1:0] last_row_q;
	logic [CH_W-1:0]  last_ch_q;

	logic [CMP_W-1:0] cfg_ext;
	logic [sg_pkg::CHAN_CFG_W-1:0] cfg_chan;
	logic [COL_W-1:0] lim_col;
	logic [ROW_W-1:0] lim_row;
	logic [CH_W-1:0]  lim_ch;
	logic             ch_end;
	logic             col_end;
	logic             row_end;

	always_comb begin
		cfg_ext = CMP_W'(cfg_data);
		cfg_chan = cfg_data[sg_pkg::CHAN_CFG_W-1:0];
		if (cfg_ext < CMP_W'(sg_pkg::MIN_DIM)) begin
			lim_col = COL_W'(sg_pkg::MIN_DIM - 1);
			lim_row = ROW_W'(sg_pkg::MIN_DIM - 1);
		end else begin
			lim_col = (cfg_ext > CMP_W'(WIDTH_LIMIT)) ? COL_W'(WIDTH_LIMIT - 1)
				: COL_W'(cfg_ext - CMP_W'(1));
			lim_row = (cfg_ext > CMP_W'(HEIGHT_LIMIT)) ? ROW_W'(HEIGHT_LIMIT - 1)
				: ROW_W'(cfg_ext - CMP_W'(1));
		end
		if (cfg_chan == '0) begin
			lim_ch = '0;
		end else if (cfg_chan > sg_pkg::CHAN_CFG_W'(MAX_CHANNELS)) begin
			lim_ch = CH_W'(MAX_CHANNELS - 1);
		end else begin
			lim_ch = CH_W'(cfg_chan - sg_pkg::CHAN_CFG_W'(1));
		end
	end

	assign cur_col = frame_begin ? '0 : col_q;
	assign cur_row = frame_begin ? '0 : row_q;
	assign cur_ch = frame_begin ? '0 : ch_q;

	assign ch_end = (cur_ch == last_ch_q);
	assign col_end = (cur_col == last_col_q);
	assign row_end = (cur_row == last_row_q);

	assign flags.interior = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
	assign flags.frame_last = ch_end && col_end && row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ch_q <= '0;
			last_col_q <= COL_W'(RST_COL);
			last_row_q <= ROW_W'(RST_ROW);
			last_ch_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sg_pkg::REG_IMAGE_WIDTH: begin
					last_col_q <= lim_col;
					col_q <= '0;
					row_q <= '0;
					ch_q <= '0;
				end
				sg_pkg::REG_IMAGE_HEIGHT: begin
					last_row_q <= lim_row;
					col_q <= '0;
					row_q <= '0;
					ch_q <= '0;
				end
				sg_pkg::REG_CHANNEL_COUNT: begin
					last_ch_q <= lim_ch;
					col_q <= '0;
					row_q <= '0;
					ch_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			ch_q <= ch_end ? '0 : cur_ch + CH_W'(1);
			if (ch_end) begin
				col_q <= col_end ? '0 : cur_col + COL_W'(1);
				if (col_end) begin
					row_q <= row_end ? '0 : cur_row + ROW_W'(1);
				end else begin
					row_q <= cur_row;
				end
			end else begin
				col_q <= cur_col;
				row_q <= cur_row;
			end
		end
	end

endmodule

// ----- sv/sg_datapath.sv -----
// Line store memory, per-channel window history, Sobel kernels and result register.
module sg_datapath #(
	parameter int MAX_CHANNELS = 4,
	parameter int COL_W = 10,
	parameter int ROW_W = 10,
	parameter int CH_W = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	sg_in_if.sink             samples,
	sg_out_if.source          results,
	input  logic [COL_W-1:0]  cur_col,
	input  logic [ROW_W-1:0]  cur_row,
	input  logic [CH_W-1:0]   cur_ch,
	input  sg_pkg::sg_flags_t flags,
	output logic              accept
);

	localparam int AW = COL_W + CH_W;
	localparam int DEPTH = 1 << AW;
	localparam int DW = sg_pkg::DATA_W;
	localparam int SUM_W = sg_pkg::GRAD_W + 1;
	localparam int COL_X = (COL_W > sg_pkg::COORD_W) ? COL_W : sg_pkg::COORD_W;
	localparam int ROW_X = (ROW_W > sg_pkg::COORD_W) ? ROW_W : sg_pkg::COORD_W;

	logic [2*DW-1:0] line_mem [DEPTH];
	sg_pkg::sg_hist_t hist_q [MAX_CHANNELS];

	logic              valid_s1;
	logic [DW-1:0]     sample_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [CH_W-1:0]   ch_s1;
	logic [AW-1:0]     addr_s1;
	logic [2*DW-1:0]   lines_s1;
	sg_pkg::sg_flags_t flags_s1;

	logic                       out_valid_q;
	logic signed [SUM_W-2:0]    grad_x_q;
	logic signed [SUM_W-2:0]    grad_y_q;
	logic [sg_pkg::COORD_W-1:0] center_col_q;
	logic [sg_pkg::COORD_W-1:0] center_row_q;
	logic [sg_pkg::CHAN_IDX_W-1:0] channel_index_q;
	logic                       frame_last_q;

	logic                adv;
	sg_pkg::sg_hist_t    hist;
	logic [DW-1:0]       top_new;
	logic [DW-1:0]       mid_new;
	logic signed [SUM_W-1:0] t0, t1, t2, m0, m2, b0, b1, b2;
	logic signed [SUM_W-1:0] gx;
	logic signed [SUM_W-1:0] gy;
	logic [COL_X-1:0]    col_m1;
	logic [ROW_X-1:0]    row_m1;

	assign adv = valid_s1 && (!out_valid_q || results.ready);
	assign samples.ready = !valid_s1 || adv;
	assign accept = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= samples.sample;
			col_s1 <= cur_col;
			row_s1 <= cur_row;
			ch_s1 <= cur_ch;
			addr_s1 <= {cur_col, cur_ch};
			flags_s1 <= flags;
		end
	end

	// The upper line store sits in the high byte, the middle one in the low byte.
	always_ff @(posedge clk) begin
		if (accept) begin
			lines_s1 <= line_mem[{cur_col, cur_ch}];
		end
		if (adv) begin
			line_mem[addr_s1] <= {mid_new, sample_s1};
		end
	end

	assign hist = hist_q[ch_s1];
	assign top_new = lines_s1[2*DW-1:DW];
	assign mid_new = lines_s1[DW-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			hist_q[ch_s1].top_old <= hist.top_new;
			hist_q[ch_s1].mid_old <= hist.mid_new;
			hist_q[ch_s1].bot_old <= hist.bot_new;
			hist_q[ch_s1].top_new <= top_new;
			hist_q[ch_s1].mid_new <= mid_new;
			hist_q[ch_s1].bot_new <= sample_s1;
		end
	end

	always_comb begin
		t0 = $signed({{(SUM_W-DW){1'b0}}, hist.top_old});
		m0 = $signed({{(SUM_W-DW){1'b0}}, hist.mid_old});
		b0 = $signed({{(SUM_W-DW){1'b0}}, hist.bot_old});
		t1 = $signed({{(SUM_W-DW){1'b0}}, hist.top_new});
		b1 = $signed({{(SUM_W-DW){1'b0}}, hist.bot_new});
		t2 = $signed({{(SUM_W-DW){1'b0}}, top_new});
		m2 = $signed({{(SUM_W-DW){1'b0}}, mid_new});
		b2 = $signed({{(SUM_W-DW){1'b0}}, sample_s1});
		gx = (t2 - t0) + ((m2 - m0) <<< 1) + (b2 - b0);
		gy = (t0 + (t1 <<< 1) + t2) - (b0 + (b1 <<< 1) + b2);
		col_m1 = COL_X'(col_s1) - COL_X'(1);
		row_m1 = ROW_X'(row_s1) - ROW_X'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= flags_s1.interior;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && flags_s1.interior) begin
			grad_x_q <= gx[SUM_W-2:0];
			grad_y_q <= gy[SUM_W-2:0];
			center_col_q <= col_m1[sg_pkg::COORD_W-1:0];
			center_row_q <= row_m1[sg_pkg::COORD_W-1:0];
			channel_index_q <= sg_pkg::CHAN_IDX_W'(ch_s1);
			frame_last_q <= flags_s1.frame_last;
		end
	end

	assign results.valid = out_valid_q;
	assign results.grad_x = grad_x_q;
	assign results.grad_y = grad_y_q;
	assign results.center_col = center_col_q;
	assign results.center_row = center_row_q;
	assign results.channel_index = channel_index_q;
	assign results.frame_last = frame_last_q;

	a_grad_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (grad_x_q >= -sg_pkg::GRAD_LIMIT) && (grad_x_q <= sg_pkg::GRAD_LIMIT))
		else $error("horizontal gradient out of range");

	a_grad_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (grad_y_q >= -sg_pkg::GRAD_LIMIT) && (grad_y_q <= sg_pkg::GRAD_LIMIT))
		else $error("vertical gradient out of range");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("item lost from the input stage while stalled");

	a_interior_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && flags_s1.interior |=> out_valid_q)
		else $error("interior item gave no result");

endmodule

// ----- sv/sobel_gradient_3x3.sv -----
// Top level of the streaming 3x3 Sobel gradient block.
// The block takes one sample item per clock while no stalled result holds the input stage.
// An item passes the input stage, where the line store memory is read through its registered
// port, and the result of the interior position whose window it completes goes to the output
// register; border positions give no result. The line store memory holds two rows of every
// column and channel and is read and written once per item. The line stores start undefined
// and need no clearing pass, so items are taken as soon as reset is released. A stalled
// result waits in the output register while the next item still enters the input stage.
module sobel_gradient_3x3 #(
	parameter int WIDTH_LIMIT = 1024,
	parameter int HEIGHT_LIMIT = 1024,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sg_in_if.sink                         samples,
	sg_out_if.source                      results,
	input  logic                          cfg_we,
	input  logic [sg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sg_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W = (WIDTH_LIMIT > 1) ? $clog2(WIDTH_LIMIT) : 1;
	localparam int ROW_W = (HEIGHT_LIMIT > 1) ? $clog2(HEIGHT_LIMIT) : 1;
	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic              accept;
	logic [COL_W-1:0]  cur_col;
	logic [ROW_W-1:0]  cur_row;
	logic [CH_W-1:0]   cur_ch;
	sg_pkg::sg_flags_t flags;

	sg_position #(
		.WIDTH_LIMIT(WIDTH_LIMIT),
		.HEIGHT_LIMIT(HEIGHT_LIMIT),
		.MAX_CHANNELS(MAX_CHANNELS),
		.COL_W(COL_W),
		.ROW_W(ROW_W),
		.CH_W(CH_W)
	) u_position (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.frame_begin(samples.frame_begin),
		.cur_col(cur_col),
		.cur_row(cur_row),
		.cur_ch(cur_ch),
		.flags(flags)
	);

	sg_datapath #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.COL_W(COL_W),
		.ROW_W(ROW_W),
		.CH_W(CH_W)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.results(results),
		.cur_col(cur_col),
		.cur_row(cur_row),
		.cur_ch(cur_ch),
		.flags(flags),
		.accept(accept)
	);

endmodule

// ----- sim/sobel_gradient_3x3_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the streaming 3x3 Sobel gradient block with a predictor.
module sobel_gradient_3x3_test;

	localparam int MAX_DIM = 1024;
	localparam int MAX_CHAN = 4;
	localparam int STORE_DEPTH = MAX_DIM * MAX_CHAN;
	localparam int HIST_DEPTH = 6 * MAX_CHAN;
	localparam int RANDOM_ITEMS = 600;
	localparam int TALL_ROWS = 24;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [sg_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic signed [sg_pkg::GRAD_W-1:0] gx;
		logic signed [sg_pkg::GRAD_W-1:0] gy;
		logic [sg_pkg::COORD_W-1:0] col;
		logic [sg_pkg::COORD_W-1:0] row;
		logic [sg_pkg::CHAN_IDX_W-1:0] chan;
		logic frame_end;
	} grad_result_t;

	typedef struct packed {
		logic [sg_pkg::DATA_W-1:0] smp;
		logic start;
		logic typed;
		logic signed [sg_pkg::GRAD_W-1:0] gx;
		logic signed [sg_pkg::GRAD_W-1:0] gy;
	} stim_row_t;

	// Three 3x3 frames: the first starts the frame, the second follows by wrap-around,
	// and the third restarts after one stray item. Each gives one result at (1, 1).
	localparam stim_row_t DIRECTED [28] = '{
		'{8'd255, 1'b1, 1'b0, 11'sd0, 11'sd0},
		'{8'd255, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd255, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b1, 11'sd0, 11'sd1020},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd255, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd255, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd255, 1'b0, 1'b1, 11'sd1020, 11'sd0},
		'{8'd17, 1'b1, 1'b0, 11'sd0, 11'sd0},
		'{8'd255, 1'b1, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd255, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd255, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b0, 11'sd0, 11'sd0},
		'{8'd0, 1'b0, 1'b1, -11'sd1020, 11'sd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [sg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sg_pkg::CFG_DATA_W-1:0] cfg_data;

	sg_in_if samples_if ();
	sg_out_if results_if ();

	sobel_gradient_3x3 dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bit [sg_pkg::DATA_W-1:0] upper_line [STORE_DEPTH];
	bit [sg_pkg::DATA_W-1:0] middle_line [STORE_DEPTH];
	bit [sg_pkg::DATA_W-1:0] col_hist [HIST_DEPTH];
	int unsigned img_w = sg_pkg::RESET_WIDTH;
	int unsigned img_h = sg_pkg::RESET_HEIGHT;
	int unsigned n_chan = 1;
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	int unsigned chan_pos = 0;

	grad_result_t expected_grads [$];
	int unsigned send_idle_pct = 33;
	int unsigned recv_idle_pct = 73;
	int unsigned fail_count = 0;
	int unsigned cycles = 0;

	task automatic sobel_predict(input logic [sg_pkg::DATA_W-1:0] s, input logic start,
		output bit produced, output grad_result_t res);
		int unsigned idx, h;
		int t0, t1, t2, m0, m2, b0, b1, b2, gx, gy;
		if (start || col_pos >= img_w || row_pos >= img_h || chan_pos >= n_chan) begin
			col_pos = 0;
			row_pos = 0;
			chan_pos = 0;
		end
		idx = col_pos * MAX_CHAN + chan_pos;
		h = chan_pos * 6;
		t0 = int'(col_hist[h]);
		m0 = int'(col_hist[h + 1]);
		b0 = int'(col_hist[h + 2]);
		t1 = int'(col_hist[h + 3]);
		b1 = int'(col_hist[h + 5]);
		t2 = int'(upper_line[idx]);
		m2 = int'(middle_line[idx]);
		b2 = int'(s);
		gx = (t2 - t0) + 2 * (m2 - m0) + (b2 - b0);
		gy = (t0 + 2 * t1 + t2) - (b0 + 2 * b1 + b2);
		produced = row_pos >= 2 && col_pos >= 2;
		res.gx = sg_pkg::GRAD_W'(gx);
		res.gy = sg_pkg::GRAD_W'(gy);
		res.col = sg_pkg::COORD_W'(col_pos - 1);
		res.row = sg_pkg::COORD_W'(row_pos - 1);
		res.chan = sg_pkg::CHAN_IDX_W'(chan_pos);
		res.frame_end = row_pos == img_h - 1 && col_pos == img_w - 1 && chan_pos == n_chan - 1;

		col_hist[h] = col_hist[h + 3];
		col_hist[h + 1] = col_hist[h + 4];
		col_hist[h + 2] = col_hist[h + 5];
		col_hist[h + 3] = upper_line[idx];
		col_hist[h + 4] = middle_line[idx];
		col_hist[h + 5] = s;
		upper_line[idx] = middle_line[idx];
		middle_line[idx] = s;

		chan_pos++;
		if (chan_pos >= n_chan) begin
			chan_pos = 0;
			col_pos++;
			if (col_pos >= img_w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= img_h)
					row_pos = 0;
			end
		end
	endtask

	function automatic int unsigned clamp_dim(logic [sg_pkg::CFG_DATA_W-1:0] v);
		if (v < sg_pkg::MIN_DIM)
			return sg_pkg::MIN_DIM;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	function automatic logic [sg_pkg::DATA_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return sg_pkg::DATA_W'($urandom_range(255));
		endcase
	endfunction

	task automatic write_one(input logic [sg_pkg::CFG_IDX_W-1:0] idx,
		input logic [sg_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			sg_pkg::REG_IMAGE_WIDTH: img_w = clamp_dim(val);
			sg_pkg::REG_IMAGE_HEIGHT: img_h = clamp_dim(val);
			sg_pkg::REG_CHANNEL_COUNT: begin
				if (val[2:0] == 3'd0)
					n_chan = 1;
				else if (val[2:0] > MAX_CHAN)
					n_chan = MAX_CHAN;
				else
					n_chan = int'(val[2:0]);
			end
			default: return;
		endcase
		col_pos = 0;
		row_pos = 0;
		chan_pos = 0;
	endtask

	task automatic configure(input logic [sg_pkg::CFG_DATA_W-1:0] w_raw,
		input logic [sg_pkg::CFG_DATA_W-1:0] h_raw,
		input logic [sg_pkg::CFG_DATA_W-1:0] c_raw, input bit spare);
		if (spare)
			write_one(REG_SPARE, sg_pkg::CFG_DATA_W'($urandom_range(2047)));
		write_one(sg_pkg::REG_IMAGE_WIDTH, w_raw);
		write_one(sg_pkg::REG_IMAGE_HEIGHT, h_raw);
		write_one(sg_pkg::REG_CHANNEL_COUNT, c_raw);
		cfg_we <= 1'b0;
	endtask

	// Valid stays high from one item to the next unless a gap is drawn.
	task automatic send_item(input logic [sg_pkg::DATA_W-1:0] s, input logic start,
		input logic typed, input logic signed [sg_pkg::GRAD_W-1:0] typed_gx,
		input logic signed [sg_pkg::GRAD_W-1:0] typed_gy);
		bit produced;
		grad_result_t res;
		if ($urandom_range(99) < send_idle_pct) begin
			samples_if.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		samples_if.valid <= 1'b1;
		samples_if.sample <= s;
		samples_if.frame_begin <= start;
		do
			@(posedge clk);
		while (samples_if.ready !== 1'b1);
		sobel_predict(s, start, produced, res);
		if (produced) begin
			if (typed)
				res = '{typed_gx, typed_gy, sg_pkg::COORD_W'(1), sg_pkg::COORD_W'(1),
					sg_pkg::CHAN_IDX_W'(0), 1'b1};
			expected_grads.push_back(res);
		end
	endtask

	task automatic send_burst(input int unsigned len, input bit lead_start,
		input int unsigned start_permille);
		logic start;
		for (int unsigned k = 0; k < len; k++) begin
			start = (k == 0 && lead_start) || $urandom_range(999) < start_permille;
			send_item(pick_sample(), start, 1'b0, '0, '0);
		end
	endtask

	task automatic wait_drained();
		samples_if.valid <= 1'b0;
		while (expected_grads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		grad_result_t got, want;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
				got = '{results_if.grad_x, results_if.grad_y, results_if.center_col,
					results_if.center_row, results_if.channel_index, results_if.frame_last};
				if (expected_grads.size() == 0) begin
					$display("%0t: unexpected item gx=%0d gy=%0d col=%0d row=%0d ch=%0d last=%0b",
						$time, got.gx, got.gy, got.col, got.row, got.chan, got.frame_end);
					fail_count++;
				end else begin
					want = expected_grads.pop_front();
					if (got !== want) begin
						$display("%0t: expected gx=%0d gy=%0d col=%0d row=%0d ch=%0d last=%0b",
							$time, want.gx, want.gy, want.col, want.row, want.chan, want.frame_end);
						$display("%0t: actual   gx=%0d gy=%0d col=%0d row=%0d ch=%0d last=%0b",
							$time, got.gx, got.gy, got.col, got.row, got.chan, got.frame_end);
						fail_count++;
					end
				end
			end
			results_if.ready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int unsigned random_items, kind, frame_len, burst_len;
		logic [sg_pkg::CFG_DATA_W-1:0] w_raw, h_raw, c_raw;
		samples_if.valid <= 1'b0;
		samples_if.sample <= '0;
		samples_if.frame_begin <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= sg_pkg::REG_IMAGE_WIDTH;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: two full rows of the default width reach the first interior results.
		send_burst(2 * sg_pkg::RESET_WIDTH + 8, 1'b0, 0);
		wait_drained();

		configure(sg_pkg::CFG_DATA_W'(3), sg_pkg::CFG_DATA_W'(3), sg_pkg::CFG_DATA_W'(1), 1'b0);
		for (int i = 0; i < $size(DIRECTED); i++)
			send_item(DIRECTED[i].smp, DIRECTED[i].start, DIRECTED[i].typed,
				DIRECTED[i].gx, DIRECTED[i].gy);
		wait_drained();

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 33;
				recv_idle_pct = 73;
			end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 73;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			w_raw = sg_pkg::CFG_DATA_W'(($urandom_range(9) == 0) ? $urandom_range(2)
				: $urandom_range(3, 12));
			h_raw = sg_pkg::CFG_DATA_W'(($urandom_range(9) == 0) ? $urandom_range(2)
				: $urandom_range(3, 6));
			c_raw = sg_pkg::CFG_DATA_W'($urandom_range(7));
			configure(w_raw, h_raw, c_raw, $urandom_range(3) == 0);
			repeat ($urandom_range(1, 3)) begin
				frame_len = img_w * img_h * n_chan;
				kind = $urandom_range(9);
				burst_len = (kind == 0) ? $urandom_range(1, frame_len - 1) : frame_len;
				send_burst(burst_len, kind != 1, 5);
				random_items += burst_len;
			end
			wait_drained();
		end

		// Tallest frame, reached through out-of-range register values; its top rows only.
		configure(sg_pkg::CFG_DATA_W'(0), sg_pkg::CFG_DATA_W'(2047), sg_pkg::CFG_DATA_W'(0),
			1'b1);
		send_burst(img_w * TALL_ROWS * n_chan, 1'b1, 0);
		wait_drained();

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
